>>> rtl/core/lrukc_pkg.sv
// ----------------------------------------------------------------------------
// LRU keyed result cache package
// Shared widths, operation codes and configuration constants.
// ----------------------------------------------------------------------------
package lrukc_pkg;
	localparam int unsigned ENTRIES_DEF   = 1024;
	localparam int unsigned CAP_W         = 11;
	localparam logic [10:0] CAPACITY_RST  = 11'd1000;
	localparam int unsigned KEY_W         = 256;
	localparam int unsigned PAY_W         = 144; // handle, tokens in/out, cost

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_PUT    = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// memory write request from the controller
	typedef struct packed {
		logic         key_we;
		logic         pay_we;
		logic [255:0] key;
		logic [143:0] pay;
	} store_wr_t;
endpackage

>>> rtl/core/lrukc_store.sv
// ----------------------------------------------------------------------------
// LRU cache entry store
// Key and payload memories, one read and one write port each, registered read.
// ----------------------------------------------------------------------------
module lrukc_store import lrukc_pkg::*; #(
	parameter int unsigned ENTRIES = ENTRIES_DEF,
	parameter int unsigned IDX_W   = $clog2(ENTRIES)
) (
	input  logic                      clk,
	input  logic [IDX_W-1:0]          rd_addr,
	output logic [KEY_W-1:0]          rd_key,
	output logic [PAY_W-1:0]          rd_pay,
	input  logic [IDX_W-1:0]          wr_addr,
	input  store_wr_t                 wr
);
	logic [KEY_W-1:0] key_mem [ENTRIES];
	logic [PAY_W-1:0] pay_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			key_mem[wr_addr] <= wr.key;
		end
		rd_key <= key_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.pay_we) begin
			pay_mem[wr_addr] <= wr.pay;
		end
		rd_pay <= pay_mem[rd_addr];
	end
endmodule

>>> rtl/core/lrukc_links.sv
// ----------------------------------------------------------------------------
// LRU cache link memories
// Newer and older neighbor links per slot, registered read, one write each.
// ----------------------------------------------------------------------------
module lrukc_links import lrukc_pkg::*; #(
	parameter int unsigned ENTRIES = ENTRIES_DEF,
	parameter int unsigned IDX_W   = $clog2(ENTRIES)
) (
	input  logic             clk,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [IDX_W-1:0] rd_newer,
	output logic [IDX_W-1:0] rd_older,
	input  logic             nw_we,
	input  logic [IDX_W-1:0] nw_addr,
	input  logic [IDX_W-1:0] nw_data,
	input  logic             od_we,
	input  logic [IDX_W-1:0] od_addr,
	input  logic [IDX_W-1:0] od_data
);
	logic [IDX_W-1:0] newer_mem [ENTRIES];
	logic [IDX_W-1:0] older_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (nw_we) begin
			newer_mem[nw_addr] <= nw_data;
		end
		rd_newer <= newer_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (od_we) begin
			older_mem[od_addr] <= od_data;
		end
		rd_older <= older_mem[rd_addr];
	end
endmodule

>>> rtl/core/lru_keyed_result_cache_unit.sv
// ----------------------------------------------------------------------------
// LRU keyed result cache
// Fully associative cache with MRU-ordered doubly linked list in memories.
// ----------------------------------------------------------------------------
// Sequence: a lookup or put scans the live entries one at a time, each by a key
// read then a compare; clear and unused kind go straight to done.
// Throughput: one transaction at a time; busy drops in the cycle done strobes.
// Results appear for one cycle on done; the receiver cannot stall.
// Reset: list pointers and entry count zero, capacity 1000; memories are not
// cleared since data read from slots that are not live is never used.
module lru_keyed_result_cache_unit import lrukc_pkg::*; #(
	parameter int unsigned ENTRIES = ENTRIES_DEF,
	parameter int unsigned IDX_W   = $clog2(ENTRIES)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [63:0] key_word0,
	input  logic [63:0] key_word1,
	input  logic [63:0] key_word2,
	input  logic [63:0] key_word3,
	input  logic [31:0] response_handle,
	input  logic [31:0] prompt_tokens,
	input  logic [31:0] completion_tokens,
	input  logic [47:0] cost,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data,
	output logic        done,
	output logic        hit,
	output logic [31:0] hit_handle,
	output logic [31:0] hit_tokens_in,
	output logic [31:0] hit_tokens_out,
	output logic [47:0] hit_cost,
	output logic        evicted,
	output logic [31:0] evicted_handle
);
	localparam int unsigned CNT_W = IDX_W + 1;
	localparam logic [CNT_W-1:0] ENT_C = CNT_W'(ENTRIES);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_SCAN  = 9'b000000010, // issue key read
		ST_CMP   = 9'b000000100, // compare read key
		ST_HITRD = 9'b000001000, // read links of hit/victim slot
		ST_HITWT = 9'b000010000,
		ST_LNK1  = 9'b000100000, // first link write
		ST_LNK2  = 9'b001000000, // second link write
		ST_LNK3  = 9'b010000000, // key and payload write (put)
		ST_DONE  = 9'b100000000
	} state_t;

	state_t             state_q;
	logic [CAP_W-1:0]   cap_q;
	logic [IDX_W-1:0]   mru_q, lru_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   scan_q;
	logic [1:0]         op_q;
	logic [KEY_W-1:0]   key_q;
	logic [PAY_W-1:0]   pay_q;
	logic [IDX_W-1:0]   slot_q;
	logic               found_q;
	logic               fresh_q;  // put inserting into new slot
	logic [IDX_W-1:0]   nw_q, od_q;
	logic               r_hit_q, r_ev_q;
	logic [PAY_W-1:0]   r_pay_q;
	logic [31:0]        r_evh_q;

	logic [CNT_W-1:0]   eff_cap;
	logic [IDX_W-1:0]   rd_addr;
	logic [KEY_W-1:0]   rd_key;
	logic [PAY_W-1:0]   rd_pay;
	logic [IDX_W-1:0]   rd_newer, rd_older;
	store_wr_t          swr;
	logic [IDX_W-1:0]   swr_addr;
	logic               nw_we, od_we;
	logic [IDX_W-1:0]   nw_addr, nw_data, od_addr, od_data;

	assign eff_cap = (32'(cap_q) > ENTRIES) ? ENT_C : CNT_W'(cap_q);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !start;

	// one read address drives the store and link memories: scan index or chosen slot
	assign rd_addr = (state_q == ST_SCAN) ? scan_q[IDX_W-1:0] : slot_q;

	lrukc_store #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_store (
		.clk(clk), .rd_addr(rd_addr), .rd_key(rd_key), .rd_pay(rd_pay),
		.wr_addr(swr_addr), .wr(swr)
	);

	lrukc_links #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_links (
		.clk(clk), .rd_addr(rd_addr), .rd_newer(rd_newer), .rd_older(rd_older),
		.nw_we(nw_we), .nw_addr(nw_addr), .nw_data(nw_data),
		.od_we(od_we), .od_addr(od_addr), .od_data(od_data)
	);

	// Link writes. Hit promote (slot not MRU, list >= 2):
	//   LNK1: older[nw]=od ; newer[od]=nw unless slot is LRU
	//   LNK2: older[slot]=mru ; newer[mru]=slot
	// Insert at front (list nonempty after victim unlink): LNK2 only.
	always_comb begin
		nw_we = 1'b0; nw_addr = '0; nw_data = '0;
		od_we = 1'b0; od_addr = '0; od_data = '0;
		unique case (state_q)
			ST_LNK1: begin
				if (found_q) begin
					od_we = 1'b1; od_addr = nw_q; od_data = od_q;
					nw_we = (slot_q != lru_q); nw_addr = od_q; nw_data = nw_q;
				end
			end
			ST_LNK2: begin
				od_we = 1'b1; od_addr = slot_q; od_data = mru_q;
				nw_we = 1'b1; nw_addr = mru_q; nw_data = slot_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		swr = '0;
		swr.key = key_q;
		swr.pay = pay_q;
		swr_addr = slot_q;
		if (state_q == ST_LNK3 && op_q == OP_PUT) begin
			swr.pay_we = 1'b1;
			swr.key_we = !found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cap_q   <= CAPACITY_RST;
			mru_q   <= '0;
			lru_q   <= '0;
			count_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						cap_q   <= cfg_data;
						count_q <= '0;
						mru_q   <= '0;
						lru_q   <= '0;
					end else if (start) begin
						op_q    <= kind;
						key_q   <= {key_word0, key_word1, key_word2, key_word3};
						pay_q   <= {response_handle, prompt_tokens, completion_tokens, cost};
						scan_q  <= '0;
						found_q <= 1'b0;
						fresh_q <= 1'b0;
						r_hit_q <= 1'b0;
						r_ev_q  <= 1'b0;
						r_pay_q <= '0;
						r_evh_q <= '0;
						if (kind == OP_CLEAR) begin
							count_q <= '0;
							mru_q   <= '0;
							lru_q   <= '0;
							state_q <= ST_DONE;
						end else if (kind == OP_NONE || eff_cap == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_q >= count_q) begin
						// miss
						if (op_q == OP_LOOKUP) begin
							state_q <= ST_DONE;
						end else if (count_q >= eff_cap) begin
							slot_q  <= lru_q;
							state_q <= ST_HITRD;
						end else begin
							slot_q  <= count_q[IDX_W-1:0];
							fresh_q <= 1'b1;
							state_q <= ST_HITRD;
						end
					end else begin
						slot_q  <= scan_q[IDX_W-1:0];
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (rd_key == key_q) begin
						found_q <= 1'b1;
						state_q <= ST_HITRD;
					end else begin
						scan_q  <= scan_q + CNT_W'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_HITRD: begin
					state_q <= ST_HITWT; // address slot_q read in this cycle
				end
				ST_HITWT: begin
					nw_q <= rd_newer;
					od_q <= rd_older;
					if (found_q) begin
						r_hit_q <= 1'b1;
						if (op_q == OP_LOOKUP) begin
							r_pay_q <= rd_pay;
						end else begin
							r_ev_q  <= 1'b1;
							r_evh_q <= rd_pay[PAY_W-1 -: 32];
						end
						state_q <= (slot_q == mru_q) ? ST_LNK3 : ST_LNK1;
					end else if (fresh_q) begin
						count_q <= count_q + CNT_W'(1);
						if (count_q == '0) begin
							lru_q   <= slot_q;
							mru_q   <= slot_q;
							state_q <= ST_LNK3;
						end else begin
							state_q <= ST_LNK2;
						end
					end else begin
						// evict LRU victim, reuse its slot
						r_ev_q  <= 1'b1;
						r_evh_q <= rd_pay[PAY_W-1 -: 32];
						if (count_q > CNT_W'(1)) begin
							lru_q   <= rd_newer;
							state_q <= ST_LNK2;
						end else begin
							mru_q   <= slot_q;
							lru_q   <= slot_q;
							state_q <= ST_LNK3;
						end
					end
				end
				ST_LNK1: begin
					if (slot_q == lru_q) begin
						lru_q <= nw_q;
					end
					state_q <= ST_LNK2;
				end
				ST_LNK2: begin
					mru_q   <= slot_q;
					state_q <= ST_LNK3;
				end
				ST_LNK3: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign hit            = r_hit_q;
	assign hit_handle     = r_pay_q[PAY_W-1 -: 32];
	assign hit_tokens_in  = r_pay_q[111:80];
	assign hit_tokens_out = r_pay_q[79:48];
	assign hit_cost       = r_pay_q[47:0];
	assign evicted        = r_ev_q;
	assign evicted_handle = r_evh_q;

`ifndef SYNTH
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ENT_C) else $error("entry count above depth");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held longer than one cycle");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted start not busy");
	a_lookup_noev: assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_q == OP_LOOKUP) |-> !evicted) else $error("lookup evicted");
`endif
endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// LRU keyed result cache testbench
// Drives lookup, put, clear and unused-kind transactions at random pacing through several
// capacity settings. A behavioral cache model predicts each result, and every
// done strobe is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import lrukc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH    = ENTRIES_DEF;
	localparam int unsigned WD_LIMIT = 40000;

	typedef struct {
		op_t          op;
		logic [255:0] key;
		logic [31:0]  handle;
		logic [31:0]  tin;
		logic [31:0]  tout;
		logic [47:0]  cst;
		bit           drain; // hold off until every prediction has been checked
	} cache_op_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] handle;
		logic [31:0] tin;
		logic [31:0] tout;
		logic [47:0] cst;
		logic        ev;
		logic [31:0] ev_handle;
	} cache_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] kind = OP_LOOKUP;
	logic [63:0] key_word0 = '0, key_word1 = '0, key_word2 = '0, key_word3 = '0;
	logic [31:0] response_handle = '0, prompt_tokens = '0, completion_tokens = '0;
	logic [47:0] cost = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [10:0] cfg_data = '0;
	logic done, hit, evicted;
	logic [31:0] hit_handle, hit_tokens_in, hit_tokens_out, evicted_handle;
	logic [47:0] hit_cost;

	lru_keyed_result_cache_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.key_word0(key_word0), .key_word1(key_word1), .key_word2(key_word2),
		.key_word3(key_word3), .response_handle(response_handle),
		.prompt_tokens(prompt_tokens), .completion_tokens(completion_tokens),
		.cost(cost),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .hit(hit), .hit_handle(hit_handle),
		.hit_tokens_in(hit_tokens_in), .hit_tokens_out(hit_tokens_out),
		.hit_cost(hit_cost), .evicted(evicted), .evicted_handle(evicted_handle)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---- cache model: slots, MRU list links, count, capacity ----
	logic [255:0] slot_key[DEPTH];
	logic [31:0]  slot_handle[DEPTH];
	logic [31:0]  slot_tin[DEPTH];
	logic [31:0]  slot_tout[DEPTH];
	logic [47:0]  slot_cost[DEPTH];
	int unsigned  link_newer[DEPTH];
	int unsigned  link_older[DEPTH];
	int unsigned  mru_slot = 0, lru_slot = 0, live_count = 0;
	logic [10:0]  capacity_reg = CAPACITY_RST;

	cache_op_t  pending_ops[$];
	cache_res_t expected_results[$];
	int unsigned fail_count = 0;
	bit no_idle = 1'b0;

	function automatic void empty_cache();
		live_count = 0;
		mru_slot = 0;
		lru_slot = 0;
	endfunction

	function automatic void to_front(int unsigned s);
		int unsigned nw, od;
		if (s == mru_slot) return;
		nw = link_newer[s];
		od = link_older[s];
		link_older[nw] = od;
		if (s == lru_slot) lru_slot = nw;
		else link_newer[od] = nw;
		link_older[s] = mru_slot;
		link_newer[mru_slot] = s;
		mru_slot = s;
	endfunction

	function automatic void link_new(int unsigned s, bit was_empty);
		if (was_empty) begin
			lru_slot = s;
		end else begin
			link_older[s] = mru_slot;
			link_newer[mru_slot] = s;
		end
		mru_slot = s;
	endfunction

	// Applies one transaction to the model and returns the result it causes.
	function automatic cache_res_t predict_cache(cache_op_t t);
		cache_res_t r;
		int unsigned cap, s;
		bit found;
		r = '0;
		found = 1'b0;
		s = 0;
		cap = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
		if (t.op == OP_CLEAR) begin
			empty_cache();
			return r;
		end
		if (t.op == OP_NONE || cap == 0) return r;
		for (int unsigned i = 0; i < live_count && !found; i++) begin
			if (slot_key[i] == t.key) begin
				found = 1'b1;
				s = i;
			end
		end
		if (t.op == OP_LOOKUP) begin
			if (found) begin
				r.hit = 1'b1;
				r.handle = slot_handle[s];
				r.tin = slot_tin[s];
				r.tout = slot_tout[s];
				r.cst = slot_cost[s];
				to_front(s);
			end
			return r;
		end
		if (found) begin
			// refresh: report the replaced handle
			r.hit = 1'b1;
			r.ev = 1'b1;
			r.ev_handle = slot_handle[s];
		end else if (live_count >= cap) begin
			s = lru_slot;
			r.ev = 1'b1;
			r.ev_handle = slot_handle[s];
			if (live_count > 1) lru_slot = link_newer[s];
			link_new(s, live_count <= 1);
			slot_key[s] = t.key;
		end else begin
			s = live_count;
			link_new(s, live_count == 0);
			live_count++;
			slot_key[s] = t.key;
		end
		slot_handle[s] = t.handle;
		slot_tin[s] = t.tin;
		slot_tout[s] = t.tout;
		slot_cost[s] = t.cst;
		if (found) to_front(s);
		return r;
	endfunction

	// ---- driver ----
	int unsigned idle_left = 0;
	always @(posedge clk) begin
		cache_op_t t;
		logic next_start;
		if (arst_n) begin
			next_start = start;
			if (start && !busy) begin
				expected_results.push_back(predict_cache(pending_ops.pop_front()));
				next_start = 1'b0;
				if (!no_idle)
					idle_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
						: $urandom_range(20, 250);
			end
			if (!next_start) begin
				if (idle_left > 0) begin
					idle_left--;
				end else if (pending_ops.size() > 0 && cfg_valid == 1'b0) begin
					t = pending_ops[0];
					// pressure: wait for the pipeline to drain first
					if (!t.drain || expected_results.size() == 0) begin
						next_start = 1'b1;
						kind <= t.op;
						{key_word0, key_word1, key_word2, key_word3} <= t.key;
						response_handle <= t.handle;
						prompt_tokens <= t.tin;
						completion_tokens <= t.tout;
						cost <= t.cst;
					end
				end
			end
			start <= next_start;
		end
	end

	// ---- monitor ----
	always @(posedge clk) begin
		cache_res_t got, want;
		if (arst_n && done) begin
			got = '{hit, hit_handle, hit_tokens_in, hit_tokens_out, hit_cost,
				evicted, evicted_handle};
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %p", $realtime, got);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					$display("%0t: expected %p actual %p", $realtime, want, got);
					fail_count++;
				end
			end
		end
	end

	// ---- watchdog: cycles with no transaction of any kind ----
	int unsigned quiet_cycles = 0;
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---- stimulus ----
	logic [255:0] key_pool[$];

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic cache_op_t make_op(op_t op, logic [255:0] k);
		cache_op_t t;
		t.op = op;
		t.key = k;
		t.handle = $urandom();
		t.tin = $urandom();
		t.tout = $urandom();
		t.cst = 48'({$urandom(), $urandom()});
		t.drain = 1'b0;
		return t;
	endfunction

	task automatic wait_idle();
		@(posedge clk);
		while (pending_ops.size() > 0 || expected_results.size() > 0 || start || busy)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_capacity(logic [10:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		capacity_reg = v;
		empty_cache();
	endtask

	task automatic random_phase(int unsigned n, int unsigned pool_n);
		cache_op_t t;
		logic [255:0] k;
		int unsigned w;
		key_pool.delete();
		for (int unsigned i = 0; i < pool_n; i++) begin
			k = {rand64(), rand64(), rand64(), rand64()};
			// near-miss keys differ from an earlier one in a single word
			if (i > 0 && $urandom_range(0, 3) == 0) begin
				k = key_pool[$urandom_range(0, i - 1)];
				w = $urandom_range(0, 3);
				k[w*64 +: 64] = k[w*64 +: 64] ^ (64'd1 << $urandom_range(0, 63));
			end
			key_pool.push_back(k);
		end
		for (int unsigned i = 0; i < n; i++) begin
			w = $urandom_range(0, 99);
			k = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, pool_n - 1)]
				: {rand64(), rand64(), rand64(), rand64()};
			if (w < 46) t = make_op(OP_LOOKUP, k);
			else if (w < 94) t = make_op(OP_PUT, k);
			else if (w < 97) t = make_op(OP_CLEAR, k);
			else t = make_op(OP_NONE, k);
			t.drain = ($urandom_range(0, 24) == 0);
			pending_ops.push_back(t);
		end
	endtask

	logic [10:0] cap_plan[9] = '{11'd1, 11'd0, 11'd2, 11'd5, 11'd2047, 11'd1024,
		11'd3, 11'd16, 11'd1000};

	initial begin
		cache_op_t t;
		logic [255:0] ka, kb;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, refresh, near-miss keys, clear, unused kind
		ka = '0;
		kb = '1;
		t = make_op(OP_PUT, ka);
		t.handle = '0; t.tin = '0; t.tout = '0; t.cst = '0;
		pending_ops.push_back(t);
		t = make_op(OP_PUT, kb);
		t.handle = '1; t.tin = '1; t.tout = '1; t.cst = '1;
		pending_ops.push_back(t);
		pending_ops.push_back(make_op(OP_LOOKUP, ka));
		pending_ops.push_back(make_op(OP_LOOKUP, kb));
		for (int w = 0; w < 4; w++) begin
			pending_ops.push_back(make_op(OP_LOOKUP, kb ^ (256'd1 << (w * 64))));
		end
		pending_ops.push_back(make_op(OP_PUT, ka));  // refresh
		pending_ops.push_back(make_op(OP_LOOKUP, ka));
		pending_ops.push_back(make_op(OP_NONE, kb));
		pending_ops.push_back(make_op(OP_CLEAR, kb));
		pending_ops.push_back(make_op(OP_LOOKUP, kb));
		write_capacity(11'd1);
		pending_ops.push_back(make_op(OP_PUT, ka));
		pending_ops.push_back(make_op(OP_PUT, kb));  // evicts the only entry
		pending_ops.push_back(make_op(OP_LOOKUP, ka));
		pending_ops.push_back(make_op(OP_LOOKUP, kb));
		write_capacity(11'd0);
		pending_ops.push_back(make_op(OP_PUT, ka));  // ignored when disabled
		pending_ops.push_back(make_op(OP_LOOKUP, ka));
		pending_ops.push_back(make_op(OP_CLEAR, ka));

		for (int p = 0; p < 9; p++) begin
			write_capacity(cap_plan[p]);
			no_idle = (p % 3 == 2);
			random_phase(63, (cap_plan[p] > 40 || cap_plan[p] == 0) ? 40
				: cap_plan[p] * 2 + 2);
		end

		wait_idle();
		repeat (50) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
